// File: hdl/axis_angle_disturbance_apply_unit_assert.svh
// Assertion macros shared by the datapath.
`ifndef AXIS_ANGLE_DISTURBANCE_APPLY_UNIT_ASSERT_SVH
`define AXIS_ANGLE_DISTURBANCE_APPLY_UNIT_ASSERT_SVH

// Check cons in the same cycle as ante.
`define AADA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante.
`define AADA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/aada_pkg.sv
package aada_pkg;

  localparam int SqSteps  = 32;
  localparam int DivSteps = 16;

  localparam logic signed [15:0] OneQ14   = 16'sd16384;
  localparam logic signed [15:0] PiQ12    = 16'sd12868;
  localparam logic signed [15:0] TwoPiQ12 = 16'sd25736;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] root;
  } sq_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [15:0] quo;
  } dv_t;

  typedef struct packed {
    logic [14:0]        ang;
    logic signed [15:0] c;
    logic signed [15:0] d0;
    logic signed [15:0] d1;
    logic signed [15:0] d2;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
  } fr_t;

  function automatic sq_t sq_step(sq_t a, logic [4:0] j);
    logic [63:0] b;
    logic [63:0] t;
    sq_t o;
    b = 64'd1 << (6'd62 - {j, 1'b0});
    t = a.root + b;
    if (a.rem >= t) begin
      o.rem  = a.rem - t;
      o.root = (a.root >> 1) + b;
    end else begin
      o.rem  = a.rem;
      o.root = a.root >> 1;
    end
    return o;
  endfunction

  function automatic dv_t dv_step(dv_t a, logic [31:0] den, logic [3:0] i);
    logic [47:0] t;
    dv_t o;
    t = {16'd0, den} << i;
    if (a.rem >= t) begin
      o.rem = a.rem - t;
      o.quo = a.quo | (16'd1 << i);
    end else begin
      o = a;
    end
    return o;
  endfunction

  function automatic logic signed [15:0] unit_out(logic [15:0] q, logic neg, logic zero);
    logic [15:0] m;
    m = (q > 16'd16384) ? 16'd16384 : q;
    if (zero) begin
      return '0;
    end
    return neg ? -$signed(m) : $signed(m);
  endfunction

endpackage

// File: hdl/aada_item_if.sv
interface aada_item_if;
  import aada_pkg::*;
  logic               valid;
  logic               ready;
  logic signed [15:0] axis_x;
  logic signed [15:0] axis_y;
  logic signed [15:0] axis_z;
  logic signed [14:0] angle_in;
  logic signed [15:0] dist_x;
  logic signed [15:0] dist_y;
  logic signed [15:0] dist_z;
  logic signed [14:0] dist_angle;

  modport source (output valid, axis_x, axis_y, axis_z, angle_in,
                  dist_x, dist_y, dist_z, dist_angle, input ready);
  modport sink (input valid, axis_x, axis_y, axis_z, angle_in,
                dist_x, dist_y, dist_z, dist_angle, output ready);
endinterface

// File: hdl/aada_result_if.sv
interface aada_result_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] new_axis_x;
  logic signed [15:0] new_axis_y;
  logic signed [15:0] new_axis_z;
  logic signed [14:0] angle_out;

  modport source (output valid, new_axis_x, new_axis_y, new_axis_z, angle_out,
                  input ready);
  modport sink (input valid, new_axis_x, new_axis_y, new_axis_z, angle_out,
                output ready);
endinterface

// File: hdl/axis_angle_disturbance_apply_unit.sv
// channel  direction  payload
// item     in         axis_x/y/z Q1.14, angle_in Q2.12, dist_x/y/z Q2.13, dist_angle Q2.12
// result   out        new_axis_x/y/z Q1.14, angle_out Q2.12
//
// One transaction enters per cycle unless a stalled result holds the pipeline.
// The pipeline holds two 32-step square root pipelines and two 16-step dividers.
// Reset clears only the stage valid bits; no clearing pass.
// A stalled result freezes every stage; item.ready is high when result.ready is high or no result is held.
`include "axis_angle_disturbance_apply_unit_assert.svh"

module axis_angle_disturbance_apply_unit
  import aada_pkg::*;
(
  input logic          clk,
  input logic          rst,
  aada_item_if.sink    item,
  aada_result_if.source result
);

  logic en;

  logic s0_v;
  fr_t  s0, s0_next;

  logic        s1_v;
  fr_t         s1;
  logic [31:0] s1_len;
  logic [28:0] s1_cc;

  logic sq_v [SqSteps];
  fr_t  sq_p [SqSteps];
  sq_t  sq_a [SqSteps];
  sq_t  sq_b [SqSteps];
  logic sq_z [SqSteps];

  logic        dv1_v   [DivSteps+1];
  fr_t         dv1_p   [DivSteps+1];
  logic [14:0] dv1_s   [DivSteps+1];
  logic [31:0] dv1_den [DivSteps+1];
  logic        dv1_z   [DivSteps+1];
  dv_t         dv1_x   [DivSteps+1];
  dv_t         dv1_y   [DivSteps+1];

  logic               uu_v;
  fr_t                uu_p;
  logic [14:0]        uu_s;
  logic signed [15:0] uu_u0, uu_u1;

  logic               ra_v;
  logic [14:0]        ra_ang;
  logic signed [15:0] ra_s;
  logic signed [31:0] ra_pud0, ra_pud1, ra_cxa, ra_cz0, ra_cz1;
  logic signed [32:0] ra_cya;
  logic signed [31:0] ra_cd [3];
  logic signed [32:0] ra_g0, ra_g1;

  logic               rb_v;
  logic [14:0]        rb_ang;
  logic signed [15:0] rb_s;
  logic signed [32:0] rb_ud;
  logic signed [32:0] rb_cr [3];
  logic signed [31:0] rb_cd [3];
  logic signed [32:0] rb_g0, rb_g1;

  logic               rc_v;
  logic [14:0]        rc_ang;
  logic signed [48:0] rc_t1 [3];
  logic signed [65:0] rc_t2 [2];
  logic signed [31:0] rc_cd [3];

  logic               rd_v;
  logic [14:0]        rd_ang;
  logic signed [63:0] rd_r [3];

  logic        ea_v;
  logic [14:0] ea_ang;
  logic [62:0] ea_m [3];
  logic        ea_n [3];

  logic        eb_v;
  logic [14:0] eb_ang;
  logic [62:0] eb_m [3];
  logic        eb_n [3];
  logic [5:0]  eb_k;
  logic [62:0] orv;
  logic [5:0]  msb;
  logic [5:0]  k_next;

  logic        ec_v;
  logic [14:0] ec_ang;
  logic [29:0] ec_w [3];
  logic        ec_n [3];

  logic        ed_v;
  logic [14:0] ed_ang;
  logic [29:0] ed_w [3];
  logic        ed_n [3];
  logic [59:0] ed_q [3];

  logic        ee_v;
  logic [14:0] ee_ang;
  logic [29:0] ee_w [3];
  logic        ee_n [3];
  logic [61:0] ee_len;

  logic        q2_v   [SqSteps];
  logic [14:0] q2_ang [SqSteps];
  logic [29:0] q2_w   [SqSteps][3];
  logic        q2_n   [SqSteps][3];
  sq_t         q2_a   [SqSteps];

  logic        dv2_v   [DivSteps+1];
  logic [14:0] dv2_ang [DivSteps+1];
  logic        dv2_n   [DivSteps+1][3];
  logic [31:0] dv2_den [DivSteps+1];
  logic        dv2_z   [DivSteps+1];
  dv_t         dv2_x   [DivSteps+1][3];

  logic               out_v;
  logic signed [15:0] out_x, out_y, out_z;
  logic [14:0]        out_ang;

  logic [16:0] magvx, magvy;
  logic [31:0] l1;
  logic [31:0] l2;

  logic out_ok;
  logic out_zero;
  logic zero_in;

  assign en         = !out_v || result.ready;
  assign item.ready = en;

  assign result.valid      = out_v;
  assign result.new_axis_x = out_x;
  assign result.new_axis_y = out_y;
  assign result.new_axis_z = out_z;
  assign result.angle_out  = $signed(out_ang);

  always_comb begin
    logic signed [15:0] sum;
    sum = 16'(item.angle_in) + 16'(item.dist_angle);
    if (sum > PiQ12) begin
      sum = sum - TwoPiQ12;
    end else if (sum <= -PiQ12) begin
      sum = sum + TwoPiQ12;
    end
    s0_next.ang = sum[14:0];
    if (item.axis_z > OneQ14) begin
      s0_next.c = OneQ14;
    end else if (item.axis_z < -OneQ14) begin
      s0_next.c = -OneQ14;
    end else begin
      s0_next.c = item.axis_z;
    end
    s0_next.d0 = item.dist_x;
    s0_next.d1 = item.dist_y;
    s0_next.d2 = item.dist_z;
    s0_next.vx = -17'(item.axis_y);
    s0_next.vy = 17'(item.axis_x);
  end

  assign magvx = sq_p[SqSteps-1].vx[16] ? 17'(-sq_p[SqSteps-1].vx) : sq_p[SqSteps-1].vx;
  assign magvy = sq_p[SqSteps-1].vy[16] ? 17'(-sq_p[SqSteps-1].vy) : sq_p[SqSteps-1].vy;
  assign l1    = sq_a[SqSteps-1].root[31:0];
  assign l2    = q2_a[SqSteps-1].root[31:0];

  always_comb begin
    orv = ea_m[0] | ea_m[1] | ea_m[2];
    msb = '0;
    for (int b = 0; b < 63; b++) begin
      if (orv[b]) begin
        msb = 6'(b);
      end
    end
    k_next = (msb > 6'd29) ? msb - 6'd29 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      for (int j = 0; j < SqSteps; j++) begin
        sq_v[j] <= 1'b0;
        q2_v[j] <= 1'b0;
      end
      for (int j = 0; j <= DivSteps; j++) begin
        dv1_v[j] <= 1'b0;
        dv2_v[j] <= 1'b0;
      end
      uu_v  <= 1'b0;
      ra_v  <= 1'b0;
      rb_v  <= 1'b0;
      rc_v  <= 1'b0;
      rd_v  <= 1'b0;
      ea_v  <= 1'b0;
      eb_v  <= 1'b0;
      ec_v  <= 1'b0;
      ed_v  <= 1'b0;
      ee_v  <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      s0_v    <= item.valid;
      s1_v    <= s0_v;
      sq_v[0] <= s1_v;
      for (int j = 1; j < SqSteps; j++) begin
        sq_v[j] <= sq_v[j-1];
      end
      dv1_v[0] <= sq_v[SqSteps-1];
      for (int j = 1; j <= DivSteps; j++) begin
        dv1_v[j] <= dv1_v[j-1];
      end
      uu_v    <= dv1_v[DivSteps];
      ra_v    <= uu_v;
      rb_v    <= ra_v;
      rc_v    <= rb_v;
      rd_v    <= rc_v;
      ea_v    <= rd_v;
      eb_v    <= ea_v;
      ec_v    <= eb_v;
      ed_v    <= ec_v;
      ee_v    <= ed_v;
      q2_v[0] <= ee_v;
      for (int j = 1; j < SqSteps; j++) begin
        q2_v[j] <= q2_v[j-1];
      end
      dv2_v[0] <= q2_v[SqSteps-1];
      for (int j = 1; j <= DivSteps; j++) begin
        dv2_v[j] <= dv2_v[j-1];
      end
      out_v <= dv2_v[DivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0 <= s0_next;

      s1     <= s0;
      s1_len <= 32'(35'(s0.vx * s0.vx) + 35'(s0.vy * s0.vy));
      s1_cc  <= 29'(30'sd268435456 - 30'(s0.c * s0.c));

      sq_p[0] <= s1;
      sq_z[0] <= (s1_len == '0);
      sq_a[0] <= sq_step('{rem: {4'd0, s1_len, 28'd0}, root: '0}, 5'd0);
      sq_b[0] <= sq_step('{rem: {35'd0, s1_cc}, root: '0}, 5'd0);
      for (int j = 1; j < SqSteps; j++) begin
        sq_p[j] <= sq_p[j-1];
        sq_z[j] <= sq_z[j-1];
        sq_a[j] <= sq_step(sq_a[j-1], 5'(j));
        sq_b[j] <= sq_step(sq_b[j-1], 5'(j));
      end

      dv1_p[0]   <= sq_p[SqSteps-1];
      dv1_s[0]   <= sq_b[SqSteps-1].root[14:0];
      dv1_den[0] <= l1;
      dv1_z[0]   <= sq_z[SqSteps-1];
      dv1_x[0]   <= '{rem: 48'({magvx, 28'd0}) + 48'(l1[31:1]), quo: '0};
      dv1_y[0]   <= '{rem: 48'({magvy, 28'd0}) + 48'(l1[31:1]), quo: '0};
      for (int j = 1; j <= DivSteps; j++) begin
        dv1_p[j]   <= dv1_p[j-1];
        dv1_s[j]   <= dv1_s[j-1];
        dv1_den[j] <= dv1_den[j-1];
        dv1_z[j]   <= dv1_z[j-1];
        dv1_x[j]   <= dv_step(dv1_x[j-1], dv1_den[j-1], 4'(DivSteps - j));
        dv1_y[j]   <= dv_step(dv1_y[j-1], dv1_den[j-1], 4'(DivSteps - j));
      end

      uu_p  <= dv1_p[DivSteps];
      uu_s  <= dv1_s[DivSteps];
      uu_u0 <= unit_out(dv1_x[DivSteps].quo, dv1_p[DivSteps].vx[16], dv1_z[DivSteps]);
      uu_u1 <= unit_out(dv1_y[DivSteps].quo, dv1_p[DivSteps].vy[16], dv1_z[DivSteps]);

      ra_ang  <= uu_p.ang;
      ra_s    <= $signed({1'b0, uu_s});
      ra_pud0 <= uu_u0 * uu_p.d0;
      ra_pud1 <= uu_u1 * uu_p.d1;
      ra_cxa  <= uu_u1 * uu_p.d2;
      ra_cya  <= -33'(uu_u0 * uu_p.d2);
      ra_cz0  <= uu_u0 * uu_p.d1;
      ra_cz1  <= uu_u1 * uu_p.d0;
      ra_cd[0] <= uu_p.c * uu_p.d0;
      ra_cd[1] <= uu_p.c * uu_p.d1;
      ra_cd[2] <= uu_p.c * uu_p.d2;
      ra_g0   <= (17'sd16384 - 17'(uu_p.c)) * 17'(uu_u0);
      ra_g1   <= (17'sd16384 - 17'(uu_p.c)) * 17'(uu_u1);

      rb_ang   <= ra_ang;
      rb_s     <= ra_s;
      rb_ud    <= 33'(ra_pud0) + 33'(ra_pud1);
      rb_cr[0] <= 33'(ra_cxa);
      rb_cr[1] <= ra_cya;
      rb_cr[2] <= 33'(ra_cz0) - 33'(ra_cz1);
      rb_cd    <= ra_cd;
      rb_g0    <= ra_g0;
      rb_g1    <= ra_g1;

      rc_ang <= rb_ang;
      rc_cd  <= rb_cd;
      for (int i = 0; i < 3; i++) begin
        rc_t1[i] <= rb_s * rb_cr[i];
      end
      rc_t2[0] <= rb_g0 * rb_ud;
      rc_t2[1] <= rb_g1 * rb_ud;

      rd_ang  <= rc_ang;
      rd_r[0] <= (64'(rc_cd[0]) <<< 28) + (64'(rc_t1[0]) <<< 14) + 64'(rc_t2[0]);
      rd_r[1] <= (64'(rc_cd[1]) <<< 28) + (64'(rc_t1[1]) <<< 14) + 64'(rc_t2[1]);
      rd_r[2] <= (64'(rc_cd[2]) <<< 28) + (64'(rc_t1[2]) <<< 14);

      ea_ang <= rd_ang;
      for (int i = 0; i < 3; i++) begin
        ea_n[i] <= rd_r[i][63];
        ea_m[i] <= rd_r[i][63] ? 63'(-rd_r[i]) : rd_r[i][62:0];
      end

      eb_ang <= ea_ang;
      eb_m   <= ea_m;
      eb_n   <= ea_n;
      eb_k   <= k_next;

      ec_ang <= eb_ang;
      ec_n   <= eb_n;
      for (int i = 0; i < 3; i++) begin
        ec_w[i] <= 30'(eb_m[i] >> eb_k);
      end

      ed_ang <= ec_ang;
      ed_w   <= ec_w;
      ed_n   <= ec_n;
      for (int i = 0; i < 3; i++) begin
        ed_q[i] <= ec_w[i] * ec_w[i];
      end

      ee_ang <= ed_ang;
      ee_w   <= ed_w;
      ee_n   <= ed_n;
      ee_len <= 62'(ed_q[0]) + 62'(ed_q[1]) + 62'(ed_q[2]);

      q2_ang[0] <= ee_ang;
      q2_w[0]   <= ee_w;
      q2_n[0]   <= ee_n;
      q2_a[0]   <= sq_step('{rem: {2'd0, ee_len}, root: '0}, 5'd0);
      for (int j = 1; j < SqSteps; j++) begin
        q2_ang[j] <= q2_ang[j-1];
        q2_w[j]   <= q2_w[j-1];
        q2_n[j]   <= q2_n[j-1];
        q2_a[j]   <= sq_step(q2_a[j-1], 5'(j));
      end

      dv2_ang[0] <= q2_ang[SqSteps-1];
      dv2_n[0]   <= q2_n[SqSteps-1];
      dv2_den[0] <= l2;
      dv2_z[0]   <= (l2 == '0);
      for (int i = 0; i < 3; i++) begin
        dv2_x[0][i] <= '{rem: 48'({q2_w[SqSteps-1][i], 14'd0}) + 48'(l2[31:1]), quo: '0};
      end
      for (int j = 1; j <= DivSteps; j++) begin
        dv2_ang[j] <= dv2_ang[j-1];
        dv2_n[j]   <= dv2_n[j-1];
        dv2_den[j] <= dv2_den[j-1];
        dv2_z[j]   <= dv2_z[j-1];
        for (int i = 0; i < 3; i++) begin
          dv2_x[j][i] <= dv_step(dv2_x[j-1][i], dv2_den[j-1], 4'(DivSteps - j));
        end
      end

      out_ang <= dv2_ang[DivSteps];
      out_x   <= unit_out(dv2_x[DivSteps][0].quo, dv2_n[DivSteps][0], dv2_z[DivSteps]);
      out_y   <= unit_out(dv2_x[DivSteps][1].quo, dv2_n[DivSteps][1], dv2_z[DivSteps]);
      out_z   <= unit_out(dv2_x[DivSteps][2].quo, dv2_n[DivSteps][2], dv2_z[DivSteps]);
    end
  end

  assign out_ok = (out_x >= -OneQ14) && (out_x <= OneQ14) &&
                  (out_y >= -OneQ14) && (out_y <= OneQ14) &&
                  (out_z >= -OneQ14) && (out_z <= OneQ14);
  assign out_zero = (out_x == 16'sd0) && (out_y == 16'sd0) && (out_z == 16'sd0);
  assign zero_in  = en && dv2_v[DivSteps] && dv2_z[DivSteps];

  `AADA_ASSERT_NOW(a_unit_range, out_v, out_ok, "new axis component out of range")
  `AADA_ASSERT_NEXT(a_stall_hold, !item.ready, $stable(sq_a[0]) && $stable(out_x), "stall moved")
  `AADA_ASSERT_NEXT(a_zero_len, zero_in, out_zero, "zero length did not give zero axis")
  `AADA_ASSERT_NOW(a_shift_range, eb_v, eb_k <= 6'd33, "block scale shift too large")

endmodule
